// ----- design/polyline_distance_to_position_assert.svh -----
// ============================================================================
// Assertion macros for the polyline distance-to-position block
// Implication checks, clocked on aclk and disabled while aresetn is low.
// ============================================================================
`ifndef POLYLINE_DISTANCE_TO_POSITION_ASSERT_SVH
`define POLYLINE_DISTANCE_TO_POSITION_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PDP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pdp assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pdp assertion failed");

`endif

// ----- design/pdp_pkg.sv -----
// ============================================================================
// pdp_pkg
// Types, codes and constants shared by the controller and the datapath.
// ============================================================================
package pdp_pkg;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

    localparam logic [6:0] WRAP_STEPS   = 7'd32;
    localparam logic [6:0] MUL_STEPS    = 7'd33;
    localparam logic [6:0] DIV_STEPS    = 7'd66;
    localparam logic [6:0] CORDIC_STEPS = 7'd24;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP,
        ST_WRAP_FIX,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LD0,
        ST_LD1,
        ST_LD2,
        ST_LAT_X,
        ST_LAT_Z,
        ST_CO_INIT,
        ST_MUL,
        ST_DIV,
        ST_CO_SUM,
        ST_HEAD_INIT,
        ST_HEAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       wr;
        logic       accept_q;
        logic       div_step;
        logic       div_wrap;
        logic       wrap_fix;
        logic       srch_cmp;
        logic       ld0;
        logic       ld1;
        logic       ld2;
        logic       lat_x;
        logic       lat_z;
        logic       co_init;
        logic       mul_step;
        logic       co_sum;
        logic       head_init;
        logic       head_step;
        logic       out_load;
        logic [1:0] coord;
        logic [4:0] step_idx;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic srch_hit;
        logic srch_last;
        logic len_pos;
        logic out_free;
    } status_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] cordic_angle(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/polyline_distance_to_position.sv -----
// ============================================================================
// polyline_distance_to_position
// Maps a distance along a waypoint polyline to a world position and heading.
// ============================================================================
//
//  Channel   Direction  Moves
//  s_*       in         waypoint write or position query request
//  m_*       out        position and heading, one per query
//  p*        in/out     APB register access (waypoint_count, track_length)
//
// A waypoint write is stored without leaving the idle state. A query on two or
// more waypoints runs the 32-step wrap division, scans the table entries in order
// for its segment and, per coordinate, runs a 33-step multiply and a 66-step
// divide on the shared serial unit; a segment of zero or negative length skips
// both. With fewer than two waypoints the sequencer goes straight to loading the
// result. Reset clears only control state; table entries are undefined until
// written. A stalled result holds in the output register; the next query may be
// computed meanwhile, but its result waits in ST_DONE until the register is free.
module polyline_distance_to_position #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [9:0]         s_entry_index,
    input  logic signed [31:0] s_way_x,
    input  logic signed [31:0] s_way_y,
    input  logic signed [31:0] s_way_z,
    input  logic [31:0]        s_way_distance,
    input  logic signed [15:0] s_way_dir_x,
    input  logic signed [15:0] s_way_dir_z,
    input  logic signed [31:0] s_query_distance,
    input  logic signed [31:0] s_query_lateral,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [15:0] m_heading
);
    import pdp_pkg::*;

    localparam logic REG_WAYPOINT_COUNT = 1'b0;
    localparam logic REG_TRACK_LENGTH   = 1'b1;

    logic [10:0] waypoint_count_reg;
    logic [31:0] track_length_reg;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waypoint_count_reg <= 11'd0;
            track_length_reg   <= 32'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_WAYPOINT_COUNT: waypoint_count_reg <= pwdata[10:0];
                REG_TRACK_LENGTH:   track_length_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WAYPOINT_COUNT: prdata = {21'd0, waypoint_count_reg};
            REG_TRACK_LENGTH:   prdata = track_length_reg;
            default:            prdata = 32'd0;
        endcase
    end

    pdp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pdp_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_count        (waypoint_count_reg),
        .cfg_length       (track_length_reg),
        .s_entry_index    (s_entry_index),
        .s_way_x          (s_way_x),
        .s_way_y          (s_way_y),
        .s_way_z          (s_way_z),
        .s_way_distance   (s_way_distance),
        .s_way_dir_x      (s_way_dir_x),
        .s_way_dir_z      (s_way_dir_z),
        .s_query_distance (s_query_distance),
        .s_query_lateral  (s_query_lateral),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_pos_z          (m_pos_z),
        .m_heading        (m_heading),
        .cmd              (cmd),
        .status           (status)
    );

`include "polyline_distance_to_position_assert.svh"

    // A query keeps the sequencer busy on the following cycle.
    `PDP_ASSERT_NEXT(a_query_busy, s_valid && s_ready && s_kind == KIND_QUERY, !s_ready)
    // A result is never loaded over one that is still waiting.
    `PDP_ASSERT_SAME(a_load_free, cmd.out_load, status.out_free)
    // The shared arithmetic unit runs one operation at a time.
    `PDP_ASSERT_SAME(a_unit_excl, 1'b1, $onehot0({cmd.mul_step, cmd.div_step, cmd.head_step}))

endmodule

// ----- design/pdp_controller.sv -----
// ============================================================================
// pdp_controller
// Sequencer for one request: wrap, segment search, interpolation, heading.
// ============================================================================
module pdp_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_kind,
    output logic              s_ready,
    input  pdp_pkg::status_t  status,
    output pdp_pkg::cmd_t     cmd
);
    import pdp_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] coord_reg, coord_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_kind == KIND_QUERY) begin
                    state_next = status.n_small ? ST_DONE : ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (cnt_reg == WRAP_STEPS - 7'd1) state_next = ST_WRAP_FIX;
            end
            ST_WRAP_FIX: state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                state_next = (status.srch_hit || status.srch_last) ? ST_LD0 : ST_SRCH_RD;
            end
            ST_LD0:     state_next = ST_LD1;
            ST_LD1:     state_next = ST_LD2;
            ST_LD2:     state_next = ST_LAT_X;
            ST_LAT_X:   state_next = ST_LAT_Z;
            ST_LAT_Z:   state_next = ST_CO_INIT;
            ST_CO_INIT: state_next = status.len_pos ? ST_MUL : ST_CO_SUM;
            ST_MUL: begin
                if (cnt_reg == MUL_STEPS - 7'd1) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == DIV_STEPS - 7'd1) state_next = ST_CO_SUM;
            end
            ST_CO_SUM:    state_next = (coord_reg == COORD_Z) ? ST_HEAD_INIT : ST_CO_INIT;
            ST_HEAD_INIT: state_next = ST_HEAD;
            ST_HEAD: begin
                if (cnt_reg == CORDIC_STEPS - 7'd1) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next   = (state_next != state_reg) ? 7'd0 : cnt_reg + 7'd1;
        coord_next = coord_reg;
        if (state_reg == ST_IDLE) begin
            coord_next = COORD_X;
        end else if (state_reg == ST_CO_SUM) begin
            coord_next = coord_reg + 2'd1;
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.coord     = coord_reg;
        cmd.step_idx  = cnt_reg[4:0];
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.wr       = s_valid && s_kind == KIND_WRITE;
                cmd.accept_q = s_valid && s_kind == KIND_QUERY;
            end
            ST_WRAP: begin
                cmd.div_step = 1'b1;
                cmd.div_wrap = 1'b1;
            end
            ST_WRAP_FIX:  cmd.wrap_fix  = 1'b1;
            ST_SRCH_CMP:  cmd.srch_cmp  = 1'b1;
            ST_LD0:       cmd.ld0       = 1'b1;
            ST_LD1:       cmd.ld1       = 1'b1;
            ST_LD2:       cmd.ld2       = 1'b1;
            ST_LAT_X:     cmd.lat_x     = 1'b1;
            ST_LAT_Z:     cmd.lat_z     = 1'b1;
            ST_CO_INIT:   cmd.co_init   = 1'b1;
            ST_MUL:       cmd.mul_step  = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_CO_SUM:    cmd.co_sum    = 1'b1;
            ST_HEAD_INIT: cmd.head_init = 1'b1;
            ST_HEAD:      cmd.head_step = 1'b1;
            ST_DONE:      cmd.out_load  = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 7'd0;
            coord_reg <= COORD_X;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            coord_reg <= coord_next;
        end
    end

endmodule

// ----- design/pdp_datapath.sv -----
// ============================================================================
// pdp_datapath
// Waypoint memory, shared serial multiply/divide unit, CORDIC and result regs.
// ============================================================================
module pdp_datapath #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         cfg_count,
    input  logic [31:0]         cfg_length,
    input  logic [9:0]          s_entry_index,
    input  logic signed [31:0]  s_way_x,
    input  logic signed [31:0]  s_way_y,
    input  logic signed [31:0]  s_way_z,
    input  logic [31:0]         s_way_distance,
    input  logic signed [15:0]  s_way_dir_x,
    input  logic signed [15:0]  s_way_dir_z,
    input  logic signed [31:0]  s_query_distance,
    input  logic signed [31:0]  s_query_lateral,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_pos_x,
    output logic signed [31:0]  m_pos_y,
    output logic signed [31:0]  m_pos_z,
    output logic signed [15:0]  m_heading,
    input  pdp_pkg::cmd_t       cmd,
    output pdp_pkg::status_t    status
);
    import pdp_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        cum_dist;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
    } entry_t;

    entry_t mem [MAX_WAYPOINTS];
    entry_t rd_data_reg;
    entry_t e0_reg, e1_reg;
    logic [AW-1:0] rd_addr;

    logic signed [31:0] d_reg, lat_reg;
    logic               simple_reg;
    logic [66:0]        md_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        r_reg;
    logic [AW-1:0]      idx_reg, seg_reg;
    logic [31:0]        prev_reg;
    logic signed [33:0] lat_x_reg, lat_z_reg;
    logic [32:0]        a_reg;
    logic               neg_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic signed [35:0] hx_reg, hy_reg;
    logic [31:0]        ang_reg;
    logic               hzero_reg;
    logic               m_valid_reg;

    // Effective count and length.
    logic [31:0] cnt32, n32;
    logic [CW-1:0] n_eff;
    logic [31:0] total;
    always_comb begin
        cnt32 = 32'(cfg_count);
        n32   = (cnt32 > 32'(MAX_WAYPOINTS)) ? 32'(MAX_WAYPOINTS) : cnt32;
        n_eff = CW'(n32);
        total = (cfg_length < 32'd256) ? 32'd256 : cfg_length;
    end

    // Segment values.
    logic signed [32:0] len33;
    logic [31:0]        len32;
    logic               len_pos;
    always_comb begin
        len33   = $signed({1'b0, e1_reg.cum_dist}) - $signed({1'b0, e0_reg.cum_dist});
        len_pos = !len33[32] && (len33 != 33'sd0);
        len32   = len33[31:0];
    end

    // Memory.
    logic wr_hit;
    assign wr_hit = cmd.wr && (32'(s_entry_index) < 32'(MAX_WAYPOINTS));

    always_comb begin
        if (cmd.ld1) begin
            rd_addr = seg_reg + AW'(1);
        end else if (cmd.ld0) begin
            rd_addr = seg_reg;
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            mem[AW'(s_entry_index)] <= '{s_way_x, s_way_y, s_way_z, s_way_distance,
                                        s_way_dir_x, s_way_dir_z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Search compare: dist[idx-1] <= r < dist[idx].
    logic srch_hit, srch_last;
    always_comb begin
        srch_hit  = (idx_reg != '0) && (prev_reg <= r_reg) && (r_reg < rd_data_reg.cum_dist);
        srch_last = (CW'(idx_reg) + CW'(1)) == n_eff;
    end

    // Shared serial unit: restoring divide and shift-add multiply.
    logic [31:0] divisor;
    logic [32:0] dtrial, ddiff;
    logic        dge;
    logic [33:0] msum;
    always_comb begin
        divisor = cmd.div_wrap ? total : len32;
        dtrial  = {rem_reg, md_reg[65]};
        ddiff   = dtrial - {1'b0, divisor};
        dge     = dtrial >= {1'b0, divisor};
        msum    = md_reg[66:33] + (md_reg[0] ? {1'b0, a_reg} : 34'd0);
    end

    // Interpolation operands for the current coordinate.
    logic signed [31:0] p0, p1;
    logic signed [33:0] off34;
    logic signed [32:0] diff33;
    logic [32:0]        off_abs, diff_abs;
    always_comb begin
        case (cmd.coord)
            COORD_X: begin p0 = e0_reg.x; p1 = e1_reg.x; end
            COORD_Y: begin p0 = e0_reg.y; p1 = e1_reg.y; end
            COORD_Z: begin p0 = e0_reg.z; p1 = e1_reg.z; end
            default: begin p0 = e0_reg.x; p1 = e1_reg.x; end
        endcase
        off34    = $signed({2'b00, r_reg}) - $signed({2'b00, e0_reg.cum_dist});
        diff33   = $signed({p1[31], p1}) - $signed({p0[31], p0});
        off_abs  = off34[33] ? 33'(-off34) : off34[32:0];
        diff_abs = diff33[32] ? 33'(-diff33) : 33'(diff33);
    end

    // Rounding, saturation and the final sum.
    logic               round_up, q_sat;
    logic [40:0]        q_mag;
    logic signed [47:0] delta, lat_term, sum48;
    logic signed [31:0] sat_sum;
    always_comb begin
        q_sat    = |md_reg[65:40];
        round_up = {rem_reg, 1'b0} >= {1'b0, len32};
        q_mag    = q_sat ? (41'd1 << 40) : ({1'b0, md_reg[39:0]} + 41'(round_up));
        if (!len_pos) begin
            delta = 48'sd0;
        end else begin
            delta = neg_reg ? -$signed({7'd0, q_mag}) : $signed({7'd0, q_mag});
        end
        case (cmd.coord)
            COORD_X: lat_term = 48'(lat_z_reg);
            COORD_Z: lat_term = -48'(lat_x_reg);
            default: lat_term = 48'sd0;
        endcase
        sum48 = 48'(p0) + delta + lat_term;
        if (sum48 > 48'sd2147483647) begin
            sat_sum = 32'sh7FFFFFFF;
        end else if (sum48 < -48'sd2147483648) begin
            sat_sum = 32'sh80000000;
        end else begin
            sat_sum = sum48[31:0];
        end
    end

    // Lateral products share one multiplier.
    logic signed [15:0] lat_dir;
    logic signed [47:0] lat_prod;
    logic signed [33:0] lat_round;
    always_comb begin
        lat_dir   = cmd.lat_z ? e0_reg.dz : e0_reg.dx;
        lat_prod  = 48'(lat_reg) * 48'(lat_dir) + 48'sd8192;
        lat_round = 34'(lat_prod >>> 14);
    end

    // CORDIC init and step.
    logic signed [35:0] hx0, hy0, hxs, hys;
    logic [31:0]        ang_step;
    logic [31:0]        ang_round;
    always_comb begin
        hx0 = 36'(e0_reg.dz);
        hy0 = 36'(e0_reg.dx);
        if (e0_reg.dz < 0) begin
            hx0 = -hx0;
            hy0 = -hy0;
        end
        hxs       = hx_reg >>> cmd.step_idx;
        hys       = hy_reg >>> cmd.step_idx;
        ang_step  = cordic_angle(cmd.step_idx);
        ang_round = ang_reg + 32'h00008000;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_q) begin
            d_reg      <= s_query_distance;
            lat_reg    <= s_query_lateral;
            simple_reg <= status.n_small;
            md_reg     <= {1'b0, (s_query_distance < 0) ? 32'(-s_query_distance)
                                                         : s_query_distance, 34'd0};
            rem_reg    <= 32'd0;
        end
        if (cmd.div_step) begin
            md_reg  <= {1'b0, md_reg[64:0], dge};
            rem_reg <= dge ? ddiff[31:0] : dtrial[31:0];
        end
        if (cmd.wrap_fix) begin
            r_reg    <= (d_reg < 0 && rem_reg != 32'd0) ? total - rem_reg : rem_reg;
            idx_reg  <= '0;
            seg_reg  <= '0;
        end
        if (cmd.srch_cmp) begin
            if (srch_hit) begin
                seg_reg <= idx_reg - AW'(1);
            end else if (!srch_last) begin
                prev_reg <= rd_data_reg.cum_dist;
                idx_reg  <= idx_reg + AW'(1);
            end
        end
        if (cmd.ld1) e0_reg <= rd_data_reg;
        if (cmd.ld2) e1_reg <= rd_data_reg;
        if (cmd.lat_x) lat_x_reg <= lat_round;
        if (cmd.lat_z) lat_z_reg <= lat_round;
        if (cmd.co_init) begin
            a_reg   <= off_abs;
            neg_reg <= off34[33] != diff33[32];
            md_reg  <= {34'd0, diff_abs};
            rem_reg <= 32'd0;
        end
        if (cmd.mul_step) begin
            md_reg <= {1'b0, msum, md_reg[32:1]};
        end
        if (cmd.co_sum) begin
            case (cmd.coord)
                COORD_X: res_x_reg <= sat_sum;
                COORD_Y: res_y_reg <= sat_sum;
                default: res_z_reg <= sat_sum;
            endcase
        end
        if (cmd.head_init) begin
            hx_reg    <= hx0 <<< 16;
            hy_reg    <= hy0 <<< 16;
            ang_reg   <= (e0_reg.dz < 0) ? 32'h80000000 : 32'h0;
            hzero_reg <= (e0_reg.dz == 16'sd0) && (e0_reg.dx == 16'sd0);
        end
        if (cmd.head_step) begin
            if (!hy_reg[35]) begin
                hx_reg  <= hx_reg + hys;
                hy_reg  <= hy_reg - hxs;
                ang_reg <= ang_reg + ang_step;
            end else begin
                hx_reg  <= hx_reg - hys;
                hy_reg  <= hy_reg + hxs;
                ang_reg <= ang_reg - ang_step;
            end
        end
        if (cmd.out_load) begin
            if (simple_reg) begin
                m_pos_x   <= d_reg;
                m_pos_y   <= 32'sd0;
                m_pos_z   <= lat_reg;
                m_heading <= 16'sd0;
            end else begin
                m_pos_x   <= res_x_reg;
                m_pos_y   <= res_y_reg;
                m_pos_z   <= res_z_reg;
                m_heading <= hzero_reg ? 16'sd0 : $signed(ang_round[31:16]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        status.n_small   = n_eff < CW'(2);
        status.srch_hit  = srch_hit;
        status.srch_last = srch_last;
        status.len_pos   = len_pos;
        status.out_free  = !m_valid_reg || m_ready;
    end

endmodule

// ----- tb/tb_polyline_distance_to_position.sv -----
// ----------------------------------------------------------------------------
// tb_polyline_distance_to_position
// Self-checking testbench for the waypoint polyline position block. A short
// directed table is followed by random phases, each of which loads a fresh
// track over the request channel, sets the registers and sends queries. Every
// query result is checked against a local model of the block.
// ----------------------------------------------------------------------------
module tb_polyline_distance_to_position;
    timeunit 1ns;
    timeprecision 1ps;

    import pdp_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 700;
    localparam int SHORT_TRACK  = 64;
    localparam int SETTLE_CYCLES = 3000;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef enum int {
        REG_WAYPOINT_COUNT = 0,
        REG_TRACK_LENGTH   = 1,
        REG_UNUSED         = 2
    } reg_index_t;

    typedef enum int { ROW_REQUEST, ROW_REGISTER } row_kind_t;

    typedef struct {
        logic               kind;
        logic [9:0]         entry;
        logic signed [31:0] x, y, z;
        logic [31:0]        cum_dist;
        logic signed [15:0] dir_x, dir_z;
        logic signed [31:0] qdist, qlat;
    } request_t;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] heading;
    } position_t;

    typedef struct {
        row_kind_t  row_kind;
        request_t   req;
        reg_index_t reg_idx;
        logic [31:0] reg_val;
        bit          typed;
        position_t   want;
    } stim_row_t;

    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = 1'b0;
    logic [9:0]         s_entry_index = '0;
    logic signed [31:0] s_way_x = '0, s_way_y = '0, s_way_z = '0;
    logic [31:0]        s_way_distance = '0;
    logic signed [15:0] s_way_dir_x = '0, s_way_dir_z = '0;
    logic signed [31:0] s_query_distance = '0, s_query_lateral = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0] m_heading;

    polyline_distance_to_position DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Local copy of the block state.
    logic signed [31:0] way_x_tbl [TABLE_DEPTH];
    logic signed [31:0] way_y_tbl [TABLE_DEPTH];
    logic signed [31:0] way_z_tbl [TABLE_DEPTH];
    logic [31:0]        way_dist_tbl [TABLE_DEPTH];
    logic signed [15:0] way_dx_tbl [TABLE_DEPTH];
    logic signed [15:0] way_dz_tbl [TABLE_DEPTH];
    logic [10:0]        cfg_count = '0;
    logic [31:0]        cfg_length = '0;

    position_t expected_positions [$];
    int errors = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int queries_sent = 0;
    int phases_run = 0;
    int cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // num * diff / len, rounded half away from zero, magnitude held at 2^40.
    function automatic longint scaled_delta(longint num, longint diff, longint len);
        logic [127:0] a, b, prod, q, rm;
        bit neg;
        neg = (num < 0) != (diff < 0);
        a = 128'(num < 0 ? -num : num);
        b = 128'(diff < 0 ? -diff : diff);
        prod = a * b;
        q = prod / 128'(len);
        rm = prod % 128'(len);
        if (q >= (128'd1 << 40)) q = 128'd1 << 40;
        else if (2 * rm >= 128'(len)) q = q + 1;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [15:0] heading_of_dir(longint dx, longint dz);
        longint cx, cy, xs, ys;
        logic [31:0] ang;
        cx = dz;
        cy = dx;
        ang = '0;
        if (cx == 0 && cy == 0) return 16'h0;
        // Vectors in the back half plane are turned around first.
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            ang = 32'h80000000;
        end
        cx = cx * 65536;
        cy = cy * 65536;
        for (int i = 0; i < 24; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0) begin
                cx = cx + ys; cy = cy - xs; ang = ang + ATAN_STEP[i];
            end else begin
                cx = cx - ys; cy = cy + xs; ang = ang - ATAN_STEP[i];
            end
        end
        ang = ang + 32'h8000;
        return ang[31:16];
    endfunction

    function automatic position_t locate_on_track(request_t r);
        position_t p;
        longint n, d, lat, total, rr, m, start, len, off, px, py, pz;
        int seg;
        n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
        d = r.qdist;
        lat = r.qlat;
        if (n < 2) begin
            p.px = r.qdist; p.py = '0; p.pz = r.qlat; p.heading = '0;
            return p;
        end
        total = (cfg_length < 256) ? 256 : longint'(cfg_length);
        if (d >= 0) rr = d % total;
        else begin
            m = (-d) % total;
            rr = (m != 0) ? total - m : 0;
        end
        seg = 0;
        for (int i = 0; i + 1 < n; i++) begin
            if (rr >= longint'(way_dist_tbl[i]) && rr < longint'(way_dist_tbl[i+1])) begin
                seg = i;
                break;
            end
        end
        start = way_dist_tbl[seg];
        len = longint'(way_dist_tbl[seg+1]) - start;
        off = rr - start;
        px = way_x_tbl[seg];
        py = way_y_tbl[seg];
        pz = way_z_tbl[seg];
        if (len >= 1) begin
            px += scaled_delta(off, longint'(way_x_tbl[seg+1]) - way_x_tbl[seg], len);
            py += scaled_delta(off, longint'(way_y_tbl[seg+1]) - way_y_tbl[seg], len);
            pz += scaled_delta(off, longint'(way_z_tbl[seg+1]) - way_z_tbl[seg], len);
        end
        px += (lat * way_dz_tbl[seg] + 8192) >>> 14;
        pz -= (lat * way_dx_tbl[seg] + 8192) >>> 14;
        p.px = 32'(sat_word(px));
        p.py = 32'(sat_word(py));
        p.pz = 32'(sat_word(pz));
        p.heading = heading_of_dir(way_dx_tbl[seg], way_dz_tbl[seg]);
        return p;
    endfunction

    // Register writes happen only with the block idle.
    task automatic write_register(reg_index_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx * 4); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_WAYPOINT_COUNT) cfg_count = value[10:0];
        else if (idx == REG_TRACK_LENGTH) cfg_length = value;
    endtask

    task automatic wait_drained();
        while (expected_positions.size() != 0) @(posedge aclk);
        // Trailing waypoint writes produce no result; let them finish.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_request(request_t r, bit typed, position_t want);
        int gap;
        gap = (requests_sent >= 300 && requests_sent < 360) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= r.kind; s_entry_index <= r.entry;
        s_way_x <= r.x; s_way_y <= r.y; s_way_z <= r.z;
        s_way_distance <= r.cum_dist;
        s_way_dir_x <= r.dir_x; s_way_dir_z <= r.dir_z;
        s_query_distance <= r.qdist; s_query_lateral <= r.qlat;
        do @(posedge aclk); while (!(s_valid && s_ready));
        requests_sent++;
        if (r.kind == KIND_WRITE) begin
            way_x_tbl[r.entry] = r.x; way_y_tbl[r.entry] = r.y; way_z_tbl[r.entry] = r.z;
            way_dist_tbl[r.entry] = r.cum_dist;
            way_dx_tbl[r.entry] = r.dir_x; way_dz_tbl[r.entry] = r.dir_z;
        end else begin
            queries_sent++;
            expected_positions.push_back(typed ? want : locate_on_track(r));
        end
    endtask

    // Called right after an accepting edge, so the request is not offered again.
    task automatic release_channel();
        s_valid <= 1'b0;
    endtask

    function automatic request_t waypoint(int slot, int x, int y, int z, logic [31:0] cum_dist,
                                          int dx, int dz);
        request_t r;
        r = '{default: '0};
        r.kind = KIND_WRITE; r.entry = slot[9:0];
        r.x = x; r.y = y; r.z = z; r.cum_dist = cum_dist;
        r.dir_x = dx[15:0]; r.dir_z = dz[15:0];
        return r;
    endfunction

    function automatic request_t query(int d, int lat);
        request_t r;
        r = '{default: '0};
        r.kind = KIND_QUERY; r.qdist = d; r.qlat = lat;
        // Unused waypoint fields still carry content.
        r.x = $urandom; r.cum_dist = $urandom; r.dir_x = $urandom;
        return r;
    endfunction

    function automatic stim_row_t req_row(request_t r);
        stim_row_t s;
        s.row_kind = ROW_REQUEST; s.req = r; s.reg_idx = REG_UNUSED; s.reg_val = '0;
        s.typed = 1'b0; s.want = '{default: '0};
        return s;
    endfunction

    function automatic stim_row_t typed_row(int d, int lat);
        stim_row_t s;
        s = req_row(query(d, lat));
        // With fewer than two waypoints the query comes back untouched.
        s.typed = 1'b1;
        s.want.px = d; s.want.py = '0; s.want.pz = lat; s.want.heading = '0;
        return s;
    endfunction

    function automatic stim_row_t reg_row(reg_index_t idx, logic [31:0] value);
        stim_row_t s;
        s = req_row(query(0, 0));
        s.row_kind = ROW_REGISTER; s.reg_idx = idx; s.reg_val = value;
        return s;
    endfunction

    function automatic int rand_coord(bit wide);
        return wide ? int'($urandom) : $signed($urandom_range(0, 32'h200000)) - 32'h100000;
    endfunction

    function automatic int rand_dir();
        return ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom)))
                                           : $signed($urandom_range(0, 32768)) - 16384;
    endfunction

    // Loads slots 0..n-1 with a track, sorted or scrambled, and returns its end.
    task automatic load_track(int n, bit sorted, bit wide, output logic [31:0] last);
        logic [31:0] cum_dist;
        position_t none;
        none = '{default: '0};
        cum_dist = $urandom_range(0, 255);
        for (int i = 0; i < n; i++) begin
            if (!sorted) cum_dist = $urandom;
            else if (i > 0 && $urandom_range(0, 7) != 0) cum_dist += $urandom_range(1, 4096);
            send_request(waypoint(i, rand_coord(wide), rand_coord(wide), rand_coord(wide),
                                  cum_dist, rand_dir(), rand_dir()), 1'b0, none);
        end
        last = cum_dist;
    endtask

    stim_row_t directed [$];

    initial begin
        int n, nq, d, lat;
        bit sorted;
        logic [31:0] last, len;
        position_t none;
        none = '{default: '0};

        directed.push_back(typed_row(32'h80000000, 32'h7FFFFFFF));
        directed.push_back(typed_row(32'h7FFFFFFF, 32'h80000000));
        directed.push_back(req_row(waypoint(0, 0, 0, 0, 0, 0, 16384)));
        directed.push_back(reg_row(REG_WAYPOINT_COUNT, 1));
        directed.push_back(typed_row(12345, -7));
        directed.push_back(req_row(waypoint(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                            32'h1000, 16384, 0)));
        directed.push_back(reg_row(REG_WAYPOINT_COUNT, 2));
        directed.push_back(reg_row(REG_TRACK_LENGTH, 0));
        directed.push_back(req_row(query(-1, 0)));
        directed.push_back(req_row(query(32'h7FFFFFFF, 32'h7FFFFFFF)));
        directed.push_back(reg_row(REG_TRACK_LENGTH, 32'hFFFFFFFF));
        directed.push_back(req_row(query(32'h800, 32'h80000000)));
        // Zero direction, and a first segment that runs backward.
        directed.push_back(req_row(waypoint(0, -5000, 77, 32'h80000000, 32'h2000, 0, 0)));
        directed.push_back(req_row(query(32'h100, 100)));
        directed.push_back(req_row(waypoint(1023, -1, -1, -1, 32'hFFFFFFFF, -1, -1)));
        directed.push_back(req_row(waypoint(1, 1000, 2000, 3000, 32'h4000, -32768, 32767)));
        directed.push_back(req_row(query(32'h3000, -32'h7FFFFFFF)));
        // Straight back along -Z gives half a turn.
        directed.push_back(req_row(waypoint(0, 0, 0, 0, 0, 0, -16384)));
        directed.push_back(req_row(query(0, 0)));
        directed.push_back(req_row(query(32'h80000000, 256)));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].row_kind == ROW_REGISTER) begin
                release_channel();
                wait_drained();
                write_register(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_request(directed[i].req, directed[i].typed, directed[i].want);
            end
        end

        while (requests_sent < RANDOM_ITEMS + directed.size()) begin
            release_channel();
            wait_drained();
            phases_run++;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 16);
            sorted = $urandom_range(0, 4) != 0;
            load_track(n, sorted, $urandom_range(0, 3) == 0, last);
            release_channel();
            wait_drained();
            case ($urandom_range(0, 5))
                0: len = 0;
                1: len = 32'hFFFFFFFF;
                2: len = $urandom;
                default: len = last + $urandom_range(0, 2048);
            endcase
            write_register(REG_WAYPOINT_COUNT, n);
            write_register(REG_TRACK_LENGTH, len);
            nq = $urandom_range(20, 60);
            for (int q = 0; q < nq; q++) begin
                if ($urandom_range(0, 5) == 0)
                    send_request(waypoint($urandom_range(n, 1023), $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom), 1'b0, none);
                d = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                : int'($urandom_range(0, len));
                lat = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                  : $signed($urandom_range(0, 8192)) - 4096;
                send_request(query(d, lat), 1'b0, none);
            end
        end

        // Evenly spaced track with the count at the table size and past it. Every
        // query lands inside the track, so the scan stops within the loaded slots.
        release_channel();
        wait_drained();
        for (int i = 0; i < SHORT_TRACK; i++) begin
            send_request(waypoint(i, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                                  32'(256 * i + 16), rand_dir(), rand_dir()), 1'b0, none);
        end
        last = 32'(256 * (SHORT_TRACK - 1) + 16);
        release_channel();
        wait_drained();
        write_register(REG_TRACK_LENGTH, last + 1);
        write_register(REG_WAYPOINT_COUNT, 1024);
        send_request(query(int'(last) - 1, 300), 1'b0, none);
        send_request(query(-300, -300), 1'b0, none);
        release_channel();
        wait_drained();
        write_register(REG_WAYPOINT_COUNT, 2047);
        send_request(query(int'(last) - 1000, 0), 1'b0, none);
        send_request(query(32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, none);
        release_channel();

        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d query results out of %0d requests over %0d random phases,",
                 results_seen, requests_sent, phases_run);
        $display("including counts at and past the table size and a long result-side stall;"
                 , " %0d errors.", errors);
        if (errors == 0 && expected_positions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: random gaps, one long hold-off, and a stretch with none.
    initial begin
        int gap;
        position_t want;
        gap = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: result with no request pending: %0d %0d %0d %0d", $time,
                             m_pos_x, m_pos_y, m_pos_z, m_heading);
                    errors++;
                end else begin
                    want = expected_positions.pop_front();
                    if (m_pos_x !== want.px) begin
                        $display("%0t: pos_x expected %0d got %0d", $time, want.px, m_pos_x);
                        errors++;
                    end
                    if (m_pos_y !== want.py) begin
                        $display("%0t: pos_y expected %0d got %0d", $time, want.py, m_pos_y);
                        errors++;
                    end
                    if (m_pos_z !== want.pz) begin
                        $display("%0t: pos_z expected %0d got %0d", $time, want.pz, m_pos_z);
                        errors++;
                    end
                    if (m_heading !== want.heading) begin
                        $display("%0t: heading expected %0d got %0d", $time, want.heading,
                                 m_heading);
                        errors++;
                    end
                end
                results_seen++;
                if (results_seen == 40) gap = 2000;
                else if (results_seen >= 200 && results_seen < 260) gap = 0;
                else gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule
